FILE: rtl/core/rlestg_pkg.sv
// ----------------------------------------------------------------------------
// rlestg_pkg
// Types and codes shared by the stego engine modules.
// ----------------------------------------------------------------------------
package rlestg_pkg;

	localparam logic [1:0] KIND_IMAGE   = 2'd0;
	localparam logic [1:0] KIND_EXTRACT = 2'd1;
	localparam logic [1:0] KIND_ACCEPT  = 2'd2;
	localparam logic [1:0] KIND_REFUSE  = 2'd3;

	localparam logic ACT_IMAGE   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	localparam logic MODE_INJECT  = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic REG_MODE      = 1'b0;
	localparam logic REG_LSB_COUNT = 1'b1;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [4:0] QUEUE_BITS = 5'd16;
	localparam logic [4:0] BYTE_BITS  = 5'd8;

	typedef struct packed {
		logic [15:0] bit_queue;
		logic [4:0]  queued_bits;
		logic        run_pending;
		logic [7:0]  pack_shift;
		logic [2:0]  packed_bits;
	} eng_state_t;

	typedef struct packed {
		logic       has;
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       mixed;
		logic       need_payload;
	} result_t;

endpackage

FILE: rtl/core/rlestg_if.sv
// ----------------------------------------------------------------------------
// rlestg_if
// Stream interfaces of the stego engine: image/payload words in, results out.
// ----------------------------------------------------------------------------
interface rlestg_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

interface rlestg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       mixed;
	logic       need_payload;

	modport source (output valid, out_byte, kind, mixed, need_payload, input ready);
	modport sink   (input valid, out_byte, kind, mixed, need_payload, output ready);
endinterface

FILE: rtl/core/rlestg_step.sv
// ----------------------------------------------------------------------------
// rlestg_step
// Next-state and result logic for one word: queue fill, run skip,
// LSB inject and LSB pack.
// ----------------------------------------------------------------------------
module rlestg_step import rlestg_pkg::*; (
	input  eng_state_t st,
	input  logic       mode,
	input  logic [2:0] lsb_count,
	input  logic       action,
	input  logic [7:0] data_byte,
	output eng_state_t st_nxt,
	output result_t    res
);

	logic [2:0]  k;
	logic [7:0]  mask;
	logic [7:0]  bits;
	logic [11:0] comb;
	logic [3:0]  total;
	logic [3:0]  sh;
	logic        is_run;

	always_comb begin
		priority if (lsb_count < 3'd1) begin
			k = 3'd1;
		end else if (lsb_count > 3'd4) begin
			k = 3'd4;
		end else begin
			k = lsb_count;
		end
	end

	assign mask   = ~(8'hFF << k);
	assign bits   = 8'(st.bit_queue >> (QUEUE_BITS - {2'b00, k})) & mask;
	assign comb   = ({4'b0000, st.pack_shift} << k) | {4'b0000, data_byte & mask};
	assign total  = {1'b0, st.packed_bits} + {1'b0, k};
	assign sh     = total - 4'd8;
	assign is_run = st.run_pending || ((data_byte & RUN_MARK) == RUN_MARK);

	always_comb begin
		st_nxt       = st;
		res.has      = 1'b0;
		res.out_byte = 8'd0;
		res.kind     = KIND_IMAGE;
		res.mixed    = 1'b0;
		if (action == ACT_PAYLOAD) begin
			res.has = 1'b1;
			if (st.queued_bits <= BYTE_BITS) begin
				st_nxt.bit_queue   = st.bit_queue |
					(16'(data_byte) << (BYTE_BITS - st.queued_bits));
				st_nxt.queued_bits = st.queued_bits + BYTE_BITS;
				res.kind           = KIND_ACCEPT;
			end else begin
				res.kind = KIND_REFUSE;
			end
		end else if (is_run) begin
			st_nxt.run_pending = !st.run_pending;
			res.has            = (mode == MODE_INJECT);
			res.out_byte       = data_byte;
		end else if (mode == MODE_INJECT) begin
			res.has      = 1'b1;
			res.out_byte = data_byte;
			if (st.queued_bits >= {2'b00, k}) begin
				res.out_byte       = (data_byte & ~mask) | bits;
				res.mixed          = 1'b1;
				st_nxt.bit_queue   = st.bit_queue << k;
				st_nxt.queued_bits = st.queued_bits - {2'b00, k};
			end
		end else begin
			if (total >= 4'd8) begin
				res.has            = 1'b1;
				res.kind           = KIND_EXTRACT;
				res.out_byte       = 8'(comb >> sh);
				st_nxt.pack_shift  = 8'(comb & ~(12'hFFF << sh));
				st_nxt.packed_bits = 3'(sh);
			end else begin
				st_nxt.pack_shift  = 8'(comb);
				st_nxt.packed_bits = 3'(total);
			end
		end
		res.need_payload = (st_nxt.queued_bits <= BYTE_BITS);
	end

endmodule

FILE: rtl/core/rle_aware_lsb_stego_engine.sv
// ----------------------------------------------------------------------------
// rle_aware_lsb_stego_engine
// LSB embed/extract engine for a run-length-coded image byte stream.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the result side accepts it, sustained. A word is
// held in the input register and its result in the result register; the rate is
// set by the queue/packer state update, which is combinational between the input
// register and the result register. Words that cause no result (run bytes and
// incomplete packs in extract mode) still pass through the input register and
// update the state. The result register lets a new word enter while a result
// waits. Write mode and lsb_count only while idle.
module rle_aware_lsb_stego_engine import rlestg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rlestg_in_if.sink    item,
	rlestg_out_if.source result,
	input  logic         wr_en,
	input  logic         wr_index,
	input  logic [2:0]   wr_data
);

	logic       mode_q;
	logic [2:0] lsb_count_q;
	eng_state_t st_q;
	eng_state_t st_nxt;
	result_t    res;

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] data_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INJECT;
			lsb_count_q <= 3'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:      mode_q      <= wr_data[0];
				REG_LSB_COUNT: lsb_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			data_s1   <= item.data_byte;
		end
	end

	rlestg_step u_step (
		.st        (st_q),
		.mode      (mode_q),
		.lsb_count (lsb_count_q),
		.action    (action_s1),
		.data_byte (data_s1),
		.st_nxt    (st_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			st_q     <= st_nxt;
			valid_s2 <= res.has;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.out_byte     = res_s2.out_byte;
	assign result.kind         = res_s2.kind;
	assign result.mixed        = res_s2.mixed;
	assign result.need_payload = res_s2.need_payload;

	ast_queue_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.queued_bits <= QUEUE_BITS)
		else $error("bit queue count out of range");

	ast_queue_tail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.bit_queue << st_q.queued_bits) == 16'd0)
		else $error("bits below queued payload not clear");

	ast_pack_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pack_shift >> st_q.packed_bits) == 8'd0)
		else $error("packer holds bits above its count");

	ast_mixed_image: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.mixed) |-> (res_s2.kind == KIND_IMAGE))
		else $error("mixed flag on a non-image word");

	ast_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(action_s1)))
		else $error("input register lost a stalled word");

endmodule

FILE: tb/rle_aware_lsb_stego_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_aware_lsb_stego_engine_test
// Drives image and payload words through the stego engine in both modes and
// at lsb_count settings 0 to 4 and 7, including the out-of-range 0 and 7. Results are
// predicted by a shadow of the queue, run-flag and packer state and checked
// field by field in order. A directed table opens the run, random streams of
// run pairs, data bytes and payload bytes follow, with random stalls on
// both sides and one long result-side hold-off in each of two phases.
// ----------------------------------------------------------------------------
module rle_aware_lsb_stego_engine_test;
	import rlestg_pkg::*;

	localparam int PHASE_WORDS    = 85;
	localparam int PHASES         = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {ROW_CFG, ROW_CHK, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t  op;
		logic       act;
		logic [7:0] dat;
		logic       idx;
		logic [2:0] val;
		logic [7:0] exp_byte;
		logic [1:0] exp_kind;
		logic       exp_mixed;
		logic       exp_need;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	logic       wr_index;
	logic [2:0] wr_data;

	rlestg_in_if  item_ch ();
	rlestg_out_if result_ch ();

	rle_aware_lsb_stego_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.wr_en  (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #2 clk = ~clk;

	// shadow of the engine
	eng_state_t engine_state;
	logic       cfg_mode;
	logic [2:0] cfg_lsb;

	result_t expected_words [$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	bit      steady_source = 1'b0;
	bit      steady_sink = 1'b0;
	bit      hold_off_request = 1'b0;

	logic [2:0] lsb_plan [PHASES] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd4, 3'd1,
		3'd0, 3'd7, 3'd2, 3'd3, 3'd7, 3'd0};

	stim_row_t directed_rows [29] = '{
		'{ROW_TYPED, ACT_IMAGE,   8'h00, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b1},
		'{ROW_TYPED, ACT_IMAGE,   8'hFF, REG_MODE, 3'd0, 8'hFF, KIND_IMAGE,  1'b0, 1'b1},
		'{ROW_TYPED, ACT_IMAGE,   8'h3A, REG_MODE, 3'd0, 8'h3A, KIND_IMAGE,  1'b0, 1'b1},
		'{ROW_TYPED, ACT_PAYLOAD, 8'hA5, REG_MODE, 3'd0, 8'h00, KIND_ACCEPT, 1'b0, 1'b1},
		'{ROW_TYPED, ACT_PAYLOAD, 8'hFF, REG_MODE, 3'd0, 8'h00, KIND_ACCEPT, 1'b0, 1'b0},
		'{ROW_TYPED, ACT_PAYLOAD, 8'h00, REG_MODE, 3'd0, 8'h00, KIND_REFUSE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'hBF, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_LSB_COUNT, 3'd4, 8'h00, KIND_IMAGE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h7F, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h80, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h00, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_LSB_COUNT, 3'd0, 8'h00, KIND_IMAGE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h55, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_LSB_COUNT, 3'd7, 8'h00, KIND_IMAGE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h3C, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_MODE, {2'b00, MODE_EXTRACT}, 8'h00, KIND_IMAGE,
			1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_LSB_COUNT, 3'd3, 8'h00, KIND_IMAGE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h07, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'hC1, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h12, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_PAYLOAD, 8'h5A, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h05, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h03, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_MODE, {2'b00, MODE_INJECT}, 8'h00, KIND_IMAGE,
			1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h2A, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_MODE, {2'b00, MODE_EXTRACT}, 8'h00, KIND_IMAGE,
			1'b0, 1'b0},
		'{ROW_CFG,   ACT_IMAGE,   8'h00, REG_LSB_COUNT, 3'd4, 8'h00, KIND_IMAGE, 1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h0F, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0},
		'{ROW_CHK,   ACT_IMAGE,   8'h0B, REG_MODE, 3'd0, 8'h00, KIND_IMAGE,  1'b0, 1'b0}
	};

	task automatic embed_extract_step(input logic act, input logic [7:0] b,
			output result_t r);
		int         k;
		int         i;
		logic [7:0] m;
		k = (cfg_lsb == 3'd0) ? 1 : (cfg_lsb > 3'd4) ? 4 : int'(cfg_lsb);
		m = 8'((1 << k) - 1);
		r = '0;
		if (act == ACT_PAYLOAD) begin
			r.has = 1'b1;
			if (engine_state.queued_bits <= 5'd8) begin
				engine_state.bit_queue = engine_state.bit_queue
					| (16'(b) << (8 - int'(engine_state.queued_bits)));
				engine_state.queued_bits = engine_state.queued_bits + BYTE_BITS;
				r.kind = KIND_ACCEPT;
			end else begin
				r.kind = KIND_REFUSE;
			end
		end else if (engine_state.run_pending || (b & RUN_MARK) == RUN_MARK) begin
			engine_state.run_pending = ~engine_state.run_pending;
			if (cfg_mode == MODE_INJECT) begin
				r.has = 1'b1;
				r.kind = KIND_IMAGE;
				r.out_byte = b;
			end
		end else if (cfg_mode == MODE_INJECT) begin
			r.has = 1'b1;
			r.kind = KIND_IMAGE;
			r.out_byte = b;
			if (int'(engine_state.queued_bits) >= k) begin
				r.out_byte = (b & ~m) | (8'(engine_state.bit_queue >> (16 - k)) & m);
				engine_state.bit_queue = engine_state.bit_queue << k;
				engine_state.queued_bits = engine_state.queued_bits - 5'(k);
				r.mixed = 1'b1;
			end
		end else begin
			for (i = k - 1; i >= 0; i--) begin
				engine_state.pack_shift = {engine_state.pack_shift[6:0], b[i]};
				if (engine_state.packed_bits == 3'd7) begin
					r.has = 1'b1;
					r.kind = KIND_EXTRACT;
					r.out_byte = engine_state.pack_shift;
					engine_state.pack_shift = '0;
					engine_state.packed_bits = '0;
				end else begin
					engine_state.packed_bits = engine_state.packed_bits + 3'd1;
				end
			end
		end
		r.need_payload = (engine_state.queued_bits <= 5'd8);
	endtask

	task automatic send_word(input logic act, input logic [7:0] b, input bit typed,
			input result_t typed_res);
		int      gap;
		result_t pred;
		gap = steady_source ? 0 : $urandom_range(15, 0);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.data_byte <= b;
		do @(posedge clk); while (!item_ch.ready);
		embed_extract_step(act, b, pred);
		if (typed)
			pred = typed_res;
		if (pred.has)
			expected_words.push_back(pred);
	endtask

	// registers change only with nothing in flight
	task automatic program_reg(input logic idx, input logic [2:0] val);
		item_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_MODE)
			cfg_mode = val[0];
		else
			cfg_lsb = val;
	endtask

	initial begin : stimulus
		int         p;
		int         sent;
		int         pick;
		int         payload_pct;
		logic [7:0] b;
		result_t    typed_res;
		stim_row_t  row;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_MODE;
		wr_data <= 3'd0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_IMAGE;
		item_ch.data_byte <= 8'h00;
		engine_state = '0;
		cfg_mode = MODE_INJECT;
		cfg_lsb = 3'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_CFG) begin
				program_reg(row.idx, row.val);
			end else begin
				typed_res = '{1'b1, row.exp_byte, row.exp_kind, row.exp_mixed, row.exp_need};
				send_word(row.act, row.dat, row.op == ROW_TYPED, typed_res);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			program_reg(REG_MODE, {2'b00, p[0] ? MODE_EXTRACT : MODE_INJECT});
			program_reg(REG_LSB_COUNT, lsb_plan[p]);
			steady_source = (p % 4 == 1) || (p % 5 == 2);
			steady_sink = (p % 4 == 3);
			if (p % 5 == 2)
				hold_off_request = 1'b1;
			payload_pct = 10 + 6 * int'((lsb_plan[p] > 3'd4) ? 3'd4 : lsb_plan[p]);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				pick = $urandom_range(99, 0);
				if (pick < payload_pct) begin
					send_word(ACT_PAYLOAD, 8'($urandom), 1'b0, '0);
					sent++;
				end else if (pick < payload_pct + 12) begin
					b = RUN_MARK | 8'($urandom_range(63, 0));
					send_word(ACT_IMAGE, b, 1'b0, '0);
					send_word(ACT_IMAGE, 8'($urandom), 1'b0, '0);
					sent += 2;
				end else begin
					b = (pick < payload_pct + 16) ? 8'($urandom) : 8'($urandom_range(8'hBF, 0));
					send_word(ACT_IMAGE, b, 1'b0, '0);
					sent++;
				end
			end
		end

		item_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("rle_aware_lsb_stego_engine_test: clean");
		else
			$display("rle_aware_lsb_stego_engine_test: errors");
		$finish;
	end

	initial begin : result_sink
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = steady_sink ? 0 : $urandom_range(15, 0);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word out_byte %02h kind %0d", $time,
					result_ch.out_byte, result_ch.kind);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (result_ch.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h", $time,
						want.out_byte, result_ch.out_byte);
					mismatches++;
				end
				if (result_ch.kind !== want.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, want.kind, result_ch.kind);
					mismatches++;
				end
				if (result_ch.mixed !== want.mixed) begin
					$display("%0t: mixed expected %0d got %0d", $time, want.mixed,
						result_ch.mixed);
					mismatches++;
				end
				if (result_ch.need_payload !== want.need_payload) begin
					$display("%0t: need_payload expected %0d got %0d", $time,
						want.need_payload, result_ch.need_payload);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("rle_aware_lsb_stego_engine_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: files.f
rtl/core/rlestg_pkg.sv
rtl/core/rlestg_if.sv
rtl/core/rlestg_step.sv
rtl/core/rle_aware_lsb_stego_engine.sv
tb/rle_aware_lsb_stego_engine_test.sv
